// ===== rtl/sbs_pkg.sv =====
`timescale 1ns / 1ps
package sbs_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW = 24;
  localparam int OutDataW = 48;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_FIX = 2'd1;
  localparam logic [1:0] KIND_TXDONE = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_SLOW_RATE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FAST_RATE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SLOW_KNOTS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FAST_KNOTS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MIN_TURN = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SLOPE_NUM = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MIN_TURN_SECS = 3'd6;

  localparam logic [8:0] FULL_CIRCLE = 9'd360;
  localparam logic [8:0] HALF_CIRCLE = 9'd180;
  localparam logic [15:0] WALK_RATE = 16'd60;
  localparam logic [8:0] WALK_TURN = 9'd30;
  localparam logic [15:0] WALK_MIN_SECS = 16'd5;
  localparam logic [15:0] ELAPSED_RESET = 16'd9000;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  function automatic logic [8:0] fold_heading(input logic [8:0] a, input logic [8:0] b);
    logic [8:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    if (d > HALF_CIRCLE) begin
      d = FULL_CIRCLE - d;
    end
    return d;
  endfunction

endpackage

// ===== rtl/smart_beacon_scheduler.sv =====
`timescale 1ns / 1ps
// A speed-scaled fix runs the shared one-bit-per-cycle divider in ST_DIV1 (8 steps for the
// turn threshold) and ST_DIV2 (16 for the rate) before ST_DONE; other items go to ST_DONE.
// Flow: one item at a time; s_tready rises again once the result enters the output
// register, which is loaded only once no held result waits for m_tready.
// Reset (rst, synchronous): control and config registers to defaults, elapsed seconds to 9000.
module smart_beacon_scheduler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // speed_knots[9:0], course_degrees[18:10], fix_good[19], manual_request[20]
  input  logic [sbs_pkg::InDataW-1:0]    s_tdata,
  // kind[1:0]
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // send_now[0], current_rate[16:1], heading_change[24:17], corner_hit[25],
  // seconds_since_send[41:26]
  output logic [sbs_pkg::OutDataW-1:0]   m_tdata,
  input  logic                           cfg_wen,
  input  logic [sbs_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [sbs_pkg::CfgDataW-1:0]   cfg_wdata
);
  import sbs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV1 = 2'd1;
  localparam logic [1:0] ST_DIV2 = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [15:0] slow_rate;
  logic [7:0]  fast_rate;
  logic [7:0]  slow_knots;
  logic [7:0]  fast_knots;
  logic [7:0]  min_turn;
  logic [7:0]  slope_num;
  logic [7:0]  min_turn_secs;

  logic [15:0] elapsed;
  logic [8:0]  last_sent_course;
  logic [8:0]  latest_course;
  logic [9:0]  top_speed;
  logic [15:0] rate_in_use;
  logic        send_pending;
  logic        tx_busy;

  logic [1:0]  state;
  logic [4:0]  count;
  logic [1:0]  kind;
  logic [9:0]  speed;
  logic [9:0]  speed_div;
  logic [8:0]  course;
  logic        good;
  logic        manual;
  logic [15:0] product;
  logic [7:0]  slope_quot;
  logic [15:0] dvd;
  logic [9:0]  rem;

  logic [10:0] rem_sh;
  logic        rem_ge;
  logic [10:0] rem_sub;
  logic [9:0]  rem_next;
  logic [15:0] dvd_next;

  logic        out_free;
  logic        in_xfer;
  logic [8:0]  in_course;
  logic [9:0]  in_speed;

  logic [15:0] elapsed_next;
  logic [8:0]  last_sent_next;
  logic [8:0]  latest_next;
  logic [9:0]  peak_next;
  logic [15:0] rate_next;
  logic        pending_next;
  logic        busy_next;
  logic        send_next;
  logic [8:0]  hc;
  logic        corner;
  logic [8:0]  thr;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign in_xfer = s_tvalid && s_tready;
  assign in_speed = s_tdata[9:0];
  assign in_course = (s_tdata[18:10] >= FULL_CIRCLE) ? (s_tdata[18:10] - FULL_CIRCLE)
                                                      : s_tdata[18:10];

  assign rem_sh = {rem, dvd[15]};
  assign rem_ge = rem_sh >= {1'b0, speed_div};
  assign rem_sub = rem_sh - {1'b0, speed_div};
  assign rem_next = rem_ge ? rem_sub[9:0] : rem_sh[9:0];
  assign dvd_next = {dvd[14:0], rem_ge};

  always_comb begin
    elapsed_next = elapsed;
    last_sent_next = last_sent_course;
    latest_next = latest_course;
    peak_next = top_speed;
    rate_next = rate_in_use;
    pending_next = send_pending;
    busy_next = tx_busy;
    send_next = 1'b0;
    hc = '0;
    corner = 1'b0;
    thr = {1'b0, min_turn} + {1'b0, slope_quot};
    unique case (kind)
      KIND_TICK: begin
        if (!send_pending && elapsed != ELAPSED_MAX) begin
          elapsed_next = elapsed + 16'd1;
        end
      end
      KIND_FIX: begin
        latest_next = course;
        if (manual && good) begin
          pending_next = 1'b1;
        end
        if (speed > top_speed) begin
          peak_next = speed;
        end
        hc = fold_heading(course, last_sent_course);
        if (speed < {2'b0, slow_knots}) begin
          rate_next = slow_rate;
          if (!(peak_next > {2'b0, slow_knots}) && speed > 10'd1) begin
            rate_next = WALK_RATE;
            corner = (hc > WALK_TURN) && (elapsed > WALK_MIN_SECS);
          end
        end else begin
          corner = (hc > thr) && (elapsed > {8'd0, min_turn_secs});
          rate_next = (speed_div > {2'b0, fast_knots}) ? {8'd0, fast_rate} : dvd;
        end
        if (elapsed > rate_next || corner) begin
          pending_next = 1'b1;
        end
      end
      KIND_TXDONE: begin
        busy_next = 1'b0;
      end
      default: begin
      end
    endcase
    if (kind != KIND_RESERVED && pending_next && !busy_next) begin
      send_next = 1'b1;
      pending_next = 1'b0;
      busy_next = 1'b1;
      elapsed_next = '0;
      last_sent_next = latest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_rate <= 16'd1800;
      fast_rate <= 8'd180;
      slow_knots <= 8'd5;
      fast_knots <= 8'd60;
      min_turn <= 8'd20;
      slope_num <= 8'd255;
      min_turn_secs <= 8'd10;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_SLOW_RATE:     slow_rate <= cfg_wdata;
        REG_FAST_RATE:     fast_rate <= cfg_wdata[7:0];
        REG_SLOW_KNOTS:    slow_knots <= cfg_wdata[7:0];
        REG_FAST_KNOTS:    fast_knots <= cfg_wdata[7:0];
        REG_MIN_TURN:      min_turn <= cfg_wdata[7:0];
        REG_SLOPE_NUM:     slope_num <= cfg_wdata[7:0];
        REG_MIN_TURN_SECS: min_turn_secs <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      m_tvalid <= 1'b0;
      elapsed <= ELAPSED_RESET;
      last_sent_course <= '0;
      latest_course <= '0;
      top_speed <= '0;
      rate_in_use <= '0;
      send_pending <= 1'b0;
      tx_busy <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            kind <= s_tuser;
            speed <= in_speed;
            speed_div <= (in_speed == '0) ? 10'd1 : in_speed;
            course <= in_course;
            good <= s_tdata[19];
            manual <= s_tdata[20];
            product <= {8'd0, fast_rate} * {8'd0, fast_knots};
            slope_quot <= '0;
            dvd <= {slope_num, 8'd0};
            rem <= '0;
            count <= 5'd8;
            if (s_tuser == KIND_FIX && in_speed >= {2'b0, slow_knots}) begin
              state <= ST_DIV1;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_DIV1: begin
          count <= count - 5'd1;
          dvd <= dvd_next;
          rem <= rem_next;
          if (count == 5'd1) begin
            slope_quot <= dvd_next[7:0];
            dvd <= product;
            rem <= '0;
            count <= 5'd16;
            state <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          count <= count - 5'd1;
          dvd <= dvd_next;
          rem <= rem_next;
          if (count == 5'd1) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            elapsed <= elapsed_next;
            last_sent_course <= last_sent_next;
            latest_course <= latest_next;
            top_speed <= peak_next;
            rate_in_use <= rate_next;
            send_pending <= pending_next;
            tx_busy <= busy_next;
            m_tdata <= {6'd0, elapsed_next, corner, hc[7:0], rate_next, send_next};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV1 || state == ST_DIV2) |-> count != 5'd0)
    else $error("divider running with zero step count");

  a_send_clears: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> m_tdata[41:26] == 16'd0)
    else $error("send reported with nonzero seconds");

  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(tx_busy) |-> (m_tvalid && m_tdata[0]))
    else $error("transmitter busy without send");

  a_no_stuck_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(send_pending && !tx_busy))
    else $error("pending beacon left with idle transmitter");
`endif

endmodule
